FILE: src/indexed_list_engine_unit_assert.svh
// Assertion macros for the indexed list engine.
// Each macro expands to one labeled concurrent assertion clocked on clock
// and disabled while reset is high.
`ifndef INDEXED_LIST_ENGINE_UNIT_ASSERT_SVH
`define INDEXED_LIST_ENGINE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ILE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ILE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/ile_pkg.sv
`timescale 1ns / 1ps

package ile_pkg;

   localparam int CAPACITY   = 64;
   localparam int WORD_WIDTH = 32;

   // Port field widths
   localparam int TYPE_W   = 3;
   localparam int POS_W    = 6;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 7;

   // Internal widths derived from capacity
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   // Compare width wide enough for position + 1 and the count
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W + 1 : POS_W + 1;

   typedef enum logic [TYPE_W-1:0] {
      OP_APPEND = 3'd0,
      OP_INSERT = 3'd1,
      OP_GET    = 3'd2,
      OP_SET    = 3'd3,
      OP_POP    = 3'd4,
      OP_DELETE = 3'd5,
      OP_TOP    = 3'd6,
      OP_FIND   = 3'd7
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_BADPOS   = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CMD_HOLD   = 2'd0,
      CMD_WRITE  = 2'd1,
      CMD_INSERT = 2'd2,
      CMD_DELETE = 2'd3
   } cmd_kind_type;

   // Broadcast to every cell of the row
   typedef struct packed {
      cmd_kind_type          kind;
      logic [IDX_W-1:0]      lo;
      logic [IDX_W-1:0]      hi;
      logic [IDX_W-1:0]      rd_sel;
      logic [WORD_WIDTH-1:0] value;
   } cell_cmd_type;

endpackage

FILE: src/indexed_list_engine_unit.sv
`timescale 1ns / 1ps

// Indexed list engine: a fixed-capacity ordered list of words.
// Request channel (req_valid / req_stall): one word per request carrying
// req_type (append, insert, get, set, pop, delete, top, find), req_position
// and req_value. A word is taken at a clock edge with valid high and stall low.
// Response channel (rsp_valid / rsp_stall): one word per request with the
// read value, found position, status and the entry count after the request.
// The request and the parallel compare of every cell are registered first;
// the shift or write then runs across the cell row and loads the response
// register, and no new request is taken until the pending one has run.
// A new request is taken while a finished response waits on a stall; it
// runs as soon as the response register frees up.
// Reset (synchronous, active high) clears every cell to zero, the count
// to zero, drops rsp_valid and req_stall; the block takes requests right after.
// While the receiver stalls, the response holds unchanged.
module indexed_list_engine_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [ile_pkg::TYPE_W-1:0]   req_type,
   input  logic [ile_pkg::POS_W-1:0]    req_position,
   input  logic [ile_pkg::VALUE_W-1:0]  req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [ile_pkg::VALUE_W-1:0]  rsp_read_value,
   output logic [ile_pkg::POS_W-1:0]    rsp_found_position,
   output logic [ile_pkg::STATUS_W-1:0] rsp_status,
   output logic [ile_pkg::COUNT_W-1:0]  rsp_item_count
);

   localparam int CAP = ile_pkg::CAPACITY;
   localparam int WW  = ile_pkg::WORD_WIDTH;

   ile_pkg::cell_cmd_type       cmd;
   logic [ile_pkg::CNT_W-1:0]   count;
   logic [WW-1:0]               req_word;
   logic [WW-1:0]               cell_word [CAP];
   logic [WW-1:0]               cell_rd [CAP];
   logic [CAP-1:0]              hits;
   logic [WW-1:0]               rd_word;

   // mask the incoming word to the list's word width
   assign req_word = WW'(req_value);

   // row of cells; each one shifts with its neighbors
   for (genvar i = 0; i < CAP; i++) begin : g_cell
      logic [WW-1:0] left_w, right_w;
      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = cell_word[i-1];
      end
      if (i == CAP - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_mid_r
         assign right_w = cell_word[i+1];
      end
      ile_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (ile_pkg::IDX_W'(i)),
         .cmd        (cmd),
         .left_word  (left_w),
         .right_word (right_w),
         .find_value (req_word),
         .count      (count),
         .word       (cell_word[i]),
         .hit        (hits[i]),
         .rd_word    (cell_rd[i])
      );
   end

   // only the selected cell drives a nonzero read word
   always_comb begin
      rd_word = '0;
      for (int i = 0; i < CAP; i++) rd_word = rd_word | cell_rd[i];
   end

   ile_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_position       (req_position),
      .hits               (hits),
      .rd_word            (rd_word),
      .req_word           (req_word),
      .cmd                (cmd),
      .count              (count),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_read_value     (rsp_read_value),
      .rsp_found_position (rsp_found_position),
      .rsp_status         (rsp_status),
      .rsp_item_count     (rsp_item_count)
   );

endmodule

FILE: src/ile_cell.sv
`timescale 1ns / 1ps

module ile_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [ile_pkg::IDX_W-1:0]      cell_index,
   input  ile_pkg::cell_cmd_type          cmd,
   input  logic [ile_pkg::WORD_WIDTH-1:0] left_word,
   input  logic [ile_pkg::WORD_WIDTH-1:0] right_word,
   input  logic [ile_pkg::WORD_WIDTH-1:0] find_value,
   input  logic [ile_pkg::CNT_W-1:0]      count,
   output logic [ile_pkg::WORD_WIDTH-1:0] word,
   output logic                           hit,
   output logic [ile_pkg::WORD_WIDTH-1:0] rd_word
);

   logic [ile_pkg::WORD_WIDTH-1:0] word_ff;
   logic [ile_pkg::WORD_WIDTH-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      unique case (cmd.kind)
         ile_pkg::CMD_HOLD: begin
            word_in = word_ff;
         end
         ile_pkg::CMD_WRITE: begin
            if (cell_index == cmd.lo) word_in = cmd.value;
         end
         ile_pkg::CMD_INSERT: begin
            // take the left neighbor inside the moved range
            if (cell_index == cmd.lo) word_in = cmd.value;
            else if (cell_index > cmd.lo && cell_index <= cmd.hi) word_in = left_word;
         end
         ile_pkg::CMD_DELETE: begin
            // take the right neighbor, clear the freed tail entry
            if (cell_index == cmd.hi) word_in = '0;
            else if (cell_index >= cmd.lo && cell_index < cmd.hi) word_in = right_word;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) word_ff <= '0;
      else       word_ff <= word_in;
   end

   assign word    = word_ff;
   assign hit     = (word_ff == find_value) &&
                    (ile_pkg::CNT_W'(cell_index) < count);
   assign rd_word = (cell_index == cmd.rd_sel) ? word_ff : '0;

endmodule

FILE: src/ile_ctrl.sv
`timescale 1ns / 1ps

module ile_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [ile_pkg::TYPE_W-1:0]     req_type,
   input  logic [ile_pkg::POS_W-1:0]      req_position,
   input  logic [ile_pkg::CAPACITY-1:0]   hits,
   input  logic [ile_pkg::WORD_WIDTH-1:0] rd_word,
   input  logic [ile_pkg::WORD_WIDTH-1:0] req_word,
   output ile_pkg::cell_cmd_type          cmd,
   output logic [ile_pkg::CNT_W-1:0]      count,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [ile_pkg::VALUE_W-1:0]    rsp_read_value,
   output logic [ile_pkg::POS_W-1:0]      rsp_found_position,
   output logic [ile_pkg::STATUS_W-1:0]   rsp_status,
   output logic [ile_pkg::COUNT_W-1:0]    rsp_item_count
);

   localparam int CMP_W = ile_pkg::CMP_W;
   localparam int IDX_W = ile_pkg::IDX_W;
   localparam int CNT_W = ile_pkg::CNT_W;

   logic                           pending_ff, pending_in;
   ile_pkg::op_type                op_ff, op_in;
   logic [ile_pkg::POS_W-1:0]      pos_ff, pos_in;
   logic [ile_pkg::WORD_WIDTH-1:0] value_ff, value_in;
   logic [ile_pkg::CAPACITY-1:0]   hits_ff, hits_in;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [ile_pkg::VALUE_W-1:0]    read_ff, read_in;
   logic [ile_pkg::POS_W-1:0]      fpos_ff, fpos_in;
   ile_pkg::status_type            status_ff, status_in;
   logic [ile_pkg::COUNT_W-1:0]    icount_ff, icount_in;

   logic                           accept, exec, rd_en;
   logic [CMP_W-1:0]               nx, px, capx;
   logic [IDX_W-1:0]               n_idx, n_m1, pos_idx, enc;
   logic [CNT_W-1:0]               cnt_next;
   logic [ile_pkg::CAPACITY-1:0]   first_hot;
   ile_pkg::cell_cmd_type          cmd_raw;
   ile_pkg::status_type            status_next;

   assign req_stall = pending_ff;
   assign accept    = req_valid && !req_stall;
   assign exec      = pending_ff && (!rsp_valid_ff || !rsp_stall);

   assign nx      = CMP_W'(count_ff);
   assign px      = CMP_W'(pos_ff);
   assign capx    = CMP_W'(ile_pkg::CAPACITY);
   assign n_idx   = IDX_W'(count_ff);
   assign n_m1    = IDX_W'(count_ff - CNT_W'(1));
   assign pos_idx = IDX_W'(pos_ff);

   // lowest set hit: isolate it, then encode the one-hot word
   assign first_hot = hits_ff & (~hits_ff + ile_pkg::CAPACITY'(1));

   always_comb begin
      enc = '0;
      for (int i = 0; i < ile_pkg::CAPACITY; i++) begin
         if (first_hot[i]) enc = enc | IDX_W'(i);
      end
   end

   always_comb begin
      cmd_raw.kind   = ile_pkg::CMD_HOLD;
      cmd_raw.lo     = pos_idx;
      cmd_raw.hi     = n_m1;
      cmd_raw.rd_sel = pos_idx;
      cmd_raw.value  = value_ff;
      status_next    = ile_pkg::ST_OK;
      rd_en          = 1'b0;
      cnt_next       = count_ff;
      fpos_in        = '0;
      unique case (op_ff)
         ile_pkg::OP_APPEND: begin
            if (nx >= capx) status_next = ile_pkg::ST_FULL;
            else begin
               cmd_raw.kind = ile_pkg::CMD_WRITE;
               cmd_raw.lo   = n_idx;
               cnt_next     = count_ff + CNT_W'(1);
            end
         end
         ile_pkg::OP_INSERT: begin
            if (px > nx) status_next = ile_pkg::ST_BADPOS;
            else if (nx >= capx) status_next = ile_pkg::ST_FULL;
            else begin
               cmd_raw.kind = ile_pkg::CMD_INSERT;
               cmd_raw.hi   = n_idx;
               cnt_next     = count_ff + CNT_W'(1);
            end
         end
         ile_pkg::OP_GET: begin
            if (px >= nx) status_next = ile_pkg::ST_BADPOS;
            else rd_en = 1'b1;
         end
         ile_pkg::OP_SET: begin
            if (px >= capx) status_next = ile_pkg::ST_BADPOS;
            else begin
               cmd_raw.kind = ile_pkg::CMD_WRITE;
               if (px >= nx) cnt_next = CNT_W'(px + CMP_W'(1));
            end
         end
         ile_pkg::OP_POP: begin
            if (count_ff == '0) status_next = ile_pkg::ST_EMPTY;
            else begin
               cmd_raw.kind   = ile_pkg::CMD_DELETE;
               cmd_raw.lo     = n_m1;
               cmd_raw.rd_sel = n_m1;
               rd_en          = 1'b1;
               cnt_next       = count_ff - CNT_W'(1);
            end
         end
         ile_pkg::OP_DELETE: begin
            if (count_ff == '0) status_next = ile_pkg::ST_EMPTY;
            else if (px >= nx) status_next = ile_pkg::ST_BADPOS;
            else begin
               cmd_raw.kind = ile_pkg::CMD_DELETE;
               cnt_next     = count_ff - CNT_W'(1);
            end
         end
         ile_pkg::OP_TOP: begin
            if (count_ff == '0) status_next = ile_pkg::ST_EMPTY;
            else begin
               cmd_raw.rd_sel = n_m1;
               rd_en          = 1'b1;
            end
         end
         ile_pkg::OP_FIND: begin
            if (hits_ff == '0) status_next = ile_pkg::ST_NOTFOUND;
            else fpos_in = ile_pkg::POS_W'(enc);
         end
      endcase
   end

   always_comb begin
      cmd = cmd_raw;
      if (!exec) cmd.kind = ile_pkg::CMD_HOLD;
   end

   always_comb begin
      pending_in   = pending_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      value_in     = value_ff;
      hits_in      = hits_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      read_in      = read_ff;
      status_in    = status_ff;
      icount_in    = icount_ff;
      if (accept) begin
         pending_in = 1'b1;
         op_in      = ile_pkg::op_type'(req_type);
         pos_in     = req_position;
         value_in   = req_word;
         hits_in    = hits;
      end
      if (exec) begin
         pending_in   = 1'b0;
         count_in     = cnt_next;
         rsp_valid_in = 1'b1;
         read_in      = rd_en ? ile_pkg::VALUE_W'(rd_word) : '0;
         status_in    = status_next;
         icount_in    = ile_pkg::COUNT_W'(cnt_next);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         op_ff        <= ile_pkg::OP_APPEND;
      end else begin
         pending_ff   <= pending_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         op_ff        <= op_in;
      end
      pos_ff    <= pos_in;
      value_ff  <= value_in;
      hits_ff   <= hits_in;
      read_ff   <= read_in;
      status_ff <= status_in;
      icount_ff <= icount_in;
      if (exec) fpos_ff <= fpos_in;
   end

   assign count              = count_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_value     = read_ff;
   assign rsp_found_position = fpos_ff;
   assign rsp_status         = status_ff;
   assign rsp_item_count     = icount_ff;

endmodule

FILE: src/ile_checker.sv
`timescale 1ns / 1ps

`include "indexed_list_engine_unit_assert.svh"

module ile_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic [ile_pkg::TYPE_W-1:0]   req_type,
   input logic [ile_pkg::POS_W-1:0]    req_position,
   input logic [ile_pkg::VALUE_W-1:0]  req_value,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [ile_pkg::VALUE_W-1:0]  rsp_read_value,
   input logic [ile_pkg::POS_W-1:0]    rsp_found_position,
   input logic [ile_pkg::STATUS_W-1:0] rsp_status,
   input logic [ile_pkg::COUNT_W-1:0]  rsp_item_count
);

   localparam logic [ile_pkg::COUNT_W-1:0] CAP_CNT = ile_pkg::COUNT_W'(ile_pkg::CAPACITY);

   // hold a stalled response word
   `ILE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_read_value) && $stable(rsp_status) &&
      $stable(rsp_item_count) && $stable(rsp_found_position),
      "stalled response changed")
   // full is only reported at capacity
   `ILE_ASSERT_NOW(a_full_cnt, rsp_valid && rsp_status == ile_pkg::ST_FULL,
      rsp_item_count == CAP_CNT, "full reported below capacity")
   // empty is only reported with no entries
   `ILE_ASSERT_NOW(a_empty_cnt, rsp_valid && rsp_status == ile_pkg::ST_EMPTY,
      rsp_item_count == '0, "empty reported with entries")
   // a miss carries no position and no read word
   `ILE_ASSERT_NOW(a_miss_zero, rsp_valid && rsp_status == ile_pkg::ST_NOTFOUND,
      rsp_found_position == '0 && rsp_read_value == '0, "miss with nonzero payload")

endmodule

bind indexed_list_engine_unit ile_checker u_ile_checker (.*);
